FILE: rtl/dep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directed Euler path check: shared definitions
// Default sizes, the queue depth and the item format between front and back.
// ----------------------------------------------------------------------------
package dep_pkg;

  localparam int LETTER_W         = 5;
  localparam int NODE_COUNT_DEF   = 26;
  localparam int DEGREE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;

  typedef struct packed {
    logic [LETTER_W-1:0] src;
    logic [LETTER_W-1:0] dst;
    logic                edge_ok;
    logic                fin;
  } dep_item_t;

endpackage

FILE: rtl/directed_euler_path_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directed Euler path check: top level
// Tests whether a stream of directed letter edges admits an Euler path.
// ----------------------------------------------------------------------------
// Each item is one edge; edges are stored at one item per cycle through a
// four-entry queue while it is not full, so the input keeps flowing while a
// result waits. The item marked final starts the evaluation, and no further
// edge is stored until its result is in the output register: a degree scan
// over every node, a decision step, then reachability sweeps over the
// adjacency rows (one row per cycle) until a sweep adds no node, at most
// NODE_COUNT sweeps, and the emit. A set that fails the degree rule skips the
// sweeps. The emit waits behind a result that is still held. Edges with a
// letter outside the node range are ignored. A failed check reports start
// node zero.
// ----------------------------------------------------------------------------
module directed_euler_path_check_core
  import dep_pkg::*;
#(
  parameter int NODE_COUNT   = NODE_COUNT_DEF,
  parameter int DEGREE_WIDTH = DEGREE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LETTER_W-1:0] in_first_letter,
  input  logic [LETTER_W-1:0] in_last_letter,
  input  logic                in_final_edge,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_path_possible,
  output logic [LETTER_W-1:0] out_start_node
);

  logic      push;
  dep_item_t push_item;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  dep_item_t head_item;

  dep_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_letter (in_first_letter),
    .in_last_letter  (in_last_letter),
    .in_final_edge   (in_final_edge),
    .push            (push),
    .push_item       (push_item),
    .q_full          (q_full)
  );

  dep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dep_back #(
    .NODE_COUNT   (NODE_COUNT),
    .DEGREE_WIDTH (DEGREE_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_item         (head_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_path_possible (out_path_possible),
    .out_start_node    (out_start_node)
  );

endmodule

FILE: rtl/dep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directed Euler path check: front end
// Accepts edge items, checks both letters against the node range and pushes
// the classified item into the queue. Stalls while the queue is full and while the input is held off after reset.
// ----------------------------------------------------------------------------
module dep_front
  import dep_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LETTER_W-1:0] in_first_letter,
  input  logic [LETTER_W-1:0] in_last_letter,
  input  logic                in_final_edge,
  output logic                push,
  output dep_item_t           push_item,
  input  logic                q_full
);

  logic src_ok;
  logic dst_ok;
  logic seen_r;
  logic seen_nxt;

  assign src_ok = 7'(in_first_letter) < 7'(NODE_COUNT);
  assign dst_ok = 7'(in_last_letter) < 7'(NODE_COUNT);

  assign in_stall          = q_full || !seen_r;
  assign push              = in_valid && !in_stall;
  assign push_item.src     = in_first_letter;
  assign push_item.dst     = in_last_letter;
  assign push_item.edge_ok = src_ok && dst_ok;
  assign push_item.fin     = in_final_edge;

  // The input is held off for the first cycle out of reset.
  assign seen_nxt = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

FILE: rtl/dep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directed Euler path check: item queue
// Small first-in first-out queue that decouples the front end from the
// evaluation back end.
// ----------------------------------------------------------------------------
module dep_queue
  import dep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dep_item_t push_item,
  output logic      q_full,
  input  logic      pop,
  output logic      head_valid,
  output dep_item_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dep_item_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/dep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directed Euler path check: back end
// Stores edges into the adjacency rows and degree counters, then on the
// final item scans the degrees, sweeps the reachability closure if the
// degree rule holds, emits the result and clears every store.
// ----------------------------------------------------------------------------
module dep_back
  import dep_pkg::*;
#(
  parameter int NODE_COUNT   = NODE_COUNT_DEF,
  parameter int DEGREE_WIDTH = DEGREE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  dep_item_t           head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_path_possible,
  output logic [LETTER_W-1:0] out_start_node
);

  localparam int IDX_W = $clog2(NODE_COUNT);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_CLOS   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic [1:0]              starts_r, starts_nxt;
  logic [1:0]              ends_r, ends_nxt;
  logic                    bad_r, bad_nxt;
  logic [IDX_W-1:0]        start_r, start_nxt;
  logic [IDX_W-1:0]        first_used_r, first_used_nxt;
  logic                    found_r, found_nxt;
  logic [NODE_COUNT-1:0]   reached_r, reached_nxt;
  logic                    changed_r, changed_nxt;
  logic                    ok_r, ok_nxt;
  logic [NODE_COUNT-1:0]   used_r, used_nxt;
  logic [NODE_COUNT-1:0]   adj_vld_r, adj_vld_nxt;
  logic [NODE_COUNT-1:0]   out_vld_r, out_vld_nxt;
  logic [NODE_COUNT-1:0]   in_vld_r, in_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_possible_r, out_possible_nxt;
  logic [LETTER_W-1:0]     out_start_r, out_start_nxt;

  logic [NODE_COUNT-1:0]   adj_row_r [NODE_COUNT];
  logic [DEGREE_WIDTH-1:0] out_deg_r [NODE_COUNT];
  logic [DEGREE_WIDTH-1:0] in_deg_r  [NODE_COUNT];

  logic [IDX_W-1:0]        src_idx;
  logic [IDX_W-1:0]        dst_idx;
  logic [IDX_W-1:0]        out_addr;
  logic [IDX_W-1:0]        in_addr;
  logic [NODE_COUNT-1:0]   row_rd;
  logic [DEGREE_WIDTH-1:0] out_rd;
  logic [DEGREE_WIDTH-1:0] in_rd;
  logic [DEGREE_WIDTH:0]   o_ext;
  logic [DEGREE_WIDTH:0]   n_ext;
  logic                    is_start;
  logic                    is_end;
  logic                    is_bal;
  logic                    last_idx;
  logic                    store_edge;
  logic                    emit_load;
  logic                    out_free;
  logic                    deg_ok;
  logic [IDX_W-1:0]        start_sel;
  logic [NODE_COUNT-1:0]   grown;
  logic [NODE_COUNT-1:0]   new_row;
  logic [DEGREE_WIDTH-1:0] out_inc;
  logic [DEGREE_WIDTH-1:0] in_inc;

  assign src_idx  = IDX_W'(head_item.src);
  assign dst_idx  = IDX_W'(head_item.dst);
  assign out_addr = (state_r == ST_IDLE) ? src_idx : scan_idx_r;
  assign in_addr  = (state_r == ST_IDLE) ? dst_idx : scan_idx_r;

  assign row_rd = adj_vld_r[out_addr] ? adj_row_r[out_addr] : '0;
  assign out_rd = out_vld_r[out_addr] ? out_deg_r[out_addr] : '0;
  assign in_rd  = in_vld_r[in_addr] ? in_deg_r[in_addr] : '0;

  assign out_inc = (&out_rd) ? out_rd : out_rd + 1'b1;
  assign in_inc  = (&in_rd) ? in_rd : in_rd + 1'b1;
  assign new_row = row_rd | (NODE_COUNT'(1) << dst_idx);

  assign o_ext    = {1'b0, out_rd};
  assign n_ext    = {1'b0, in_rd};
  assign is_bal   = o_ext == n_ext;
  assign is_start = o_ext == n_ext + 1'b1;
  assign is_end   = n_ext == o_ext + 1'b1;
  assign last_idx = scan_idx_r == IDX_W'(NODE_COUNT - 1);
  assign grown    = reached_r | row_rd;

  assign deg_ok    = !bad_r && ((starts_r == 2'd1 && ends_r == 2'd1) ||
                                (starts_r == 2'd0 && ends_r == 2'd0));
  assign start_sel = (starts_r != 2'd0) ? start_r : (found_r ? first_used_r : '0);

  assign pop        = (state_r == ST_IDLE) && head_valid;
  assign store_edge = pop && head_item.edge_ok;
  assign out_free   = !out_valid_r || !out_stall;
  assign emit_load  = (state_r == ST_EMIT) && out_free;

  assign out_valid         = out_valid_r;
  assign out_path_possible = out_possible_r;
  assign out_start_node    = out_start_r;

  always_comb begin
    state_nxt        = state_r;
    scan_idx_nxt     = scan_idx_r;
    starts_nxt       = starts_r;
    ends_nxt         = ends_r;
    bad_nxt          = bad_r;
    start_nxt        = start_r;
    first_used_nxt   = first_used_r;
    found_nxt        = found_r;
    reached_nxt      = reached_r;
    changed_nxt      = changed_r;
    ok_nxt           = ok_r;
    used_nxt         = used_r;
    adj_vld_nxt      = adj_vld_r;
    out_vld_nxt      = out_vld_r;
    in_vld_nxt       = in_vld_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_possible_nxt = out_possible_r;
    out_start_nxt    = out_start_r;

    case (state_r)
      ST_IDLE: begin
        if (store_edge) begin
          used_nxt[src_idx]    = 1'b1;
          used_nxt[dst_idx]    = 1'b1;
          adj_vld_nxt[src_idx] = 1'b1;
          out_vld_nxt[src_idx] = 1'b1;
          in_vld_nxt[dst_idx]  = 1'b1;
        end
        if (pop && head_item.fin) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          starts_nxt   = '0;
          ends_nxt     = '0;
          bad_nxt      = 1'b0;
          start_nxt    = '0;
          found_nxt    = 1'b0;
          first_used_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (!is_bal) begin
          if (is_start) begin
            starts_nxt = (starts_r == 2'd2) ? starts_r : starts_r + 1'b1;
            start_nxt  = scan_idx_r;
          end else if (is_end) begin
            ends_nxt = (ends_r == 2'd2) ? ends_r : ends_r + 1'b1;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        if (used_r[scan_idx_r] && !found_r) begin
          found_nxt      = 1'b1;
          first_used_nxt = scan_idx_r;
        end
        if (last_idx) begin
          state_nxt = ST_DECIDE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        start_nxt = start_sel;
        if (deg_ok) begin
          reached_nxt            = '0;
          reached_nxt[start_sel] = 1'b1;
          scan_idx_nxt           = '0;
          changed_nxt            = 1'b0;
          state_nxt              = ST_CLOS;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_CLOS: begin
        if (reached_r[scan_idx_r]) begin
          reached_nxt = grown;
          if (grown != reached_r) begin
            changed_nxt = 1'b1;
          end
        end
        if (last_idx) begin
          scan_idx_nxt = '0;
          changed_nxt  = 1'b0;
          if (!(changed_r || (reached_r[scan_idx_r] && grown != reached_r))) begin
            ok_nxt    = (used_r & ~reached_r) == '0;
            state_nxt = ST_EMIT;
          end
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_possible_nxt = ok_r;
          out_start_nxt    = ok_r ? LETTER_W'(start_r) : '0;
          used_nxt         = '0;
          reached_nxt      = '0;
          adj_vld_nxt      = '0;
          out_vld_nxt      = '0;
          in_vld_nxt       = '0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      starts_r    <= '0;
      ends_r      <= '0;
      bad_r       <= 1'b0;
      found_r     <= 1'b0;
      changed_r   <= 1'b0;
      ok_r        <= 1'b0;
      used_r      <= '0;
      reached_r   <= '0;
      adj_vld_r   <= '0;
      out_vld_r   <= '0;
      in_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      starts_r    <= starts_nxt;
      ends_r      <= ends_nxt;
      bad_r       <= bad_nxt;
      found_r     <= found_nxt;
      changed_r   <= changed_nxt;
      ok_r        <= ok_nxt;
      used_r      <= used_nxt;
      reached_r   <= reached_nxt;
      adj_vld_r   <= adj_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      in_vld_r    <= in_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r        <= start_nxt;
    first_used_r   <= first_used_nxt;
    out_possible_r <= out_possible_nxt;
    out_start_r    <= out_start_nxt;
    if (store_edge) begin
      adj_row_r[src_idx] <= new_row;
      out_deg_r[src_idx] <= out_inc;
      in_deg_r[dst_idx]  <= in_inc;
    end
  end

  // Edges are only taken while no evaluation is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_IDLE)
    else $error("item taken during evaluation");

  // Emitting a result leaves every store empty for the next set.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> (used_r == '0 && adj_vld_r == '0 && out_vld_r == '0 &&
                   in_vld_r == '0 && state_r == ST_IDLE))
    else $error("stores not cleared after result");

  // A failed check always reports node zero as its start.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_possible_r) |-> out_start_r == '0)
    else $error("failed check with nonzero start node");

  // The walk index never leaves the node range.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_CLOS) |->
      32'(scan_idx_r) < 32'(NODE_COUNT))
    else $error("walk index out of range");

  // A pending result is held until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_possible_r) &&
                                    $stable(out_start_r)))
    else $error("pending result changed");

endmodule
